// ===== hw/rtl/gptb_pkg.sv =====
`default_nettype none
package gptb_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Z  = 3'd1;
  localparam logic [2:0] CFG_SPACING_X = 3'd2;
  localparam logic [2:0] CFG_SPACING_Z = 3'd3;

  localparam int CW  = 32;  // coordinate width
  localparam int SPW = 31;  // spacing width
  localparam int WW  = 21;  // weight width
  localparam int FW  = 13;  // face index width
  localparam int QV  = 17;  // weight quotient bits
  localparam int RWV = 49;  // weight remainder width

  localparam logic [WW-1:0]  ONE_Q16       = 21'd65536;
  localparam logic [SPW-1:0] SPACING_RESET = 31'd65536;

  // Sideband of the weight division chain.
  typedef struct packed {
    logic          miss;
    logic [FW-1:0] face;
    logic          neg_v;
    logic          neg_w;
  } wside_t;

endpackage
`default_nettype wire

// ===== hw/rtl/gptb_div_cell.sv =====
`default_nettype none
// One restoring division step against the divisor shifted by SHIFT.
module gptb_div_cell #(
  parameter int RW    = 49,
  parameter int DW    = 31,
  parameter int QW    = 17,
  parameter int SHIFT = 0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [RW-1:0] rem_i,
  input  wire logic [QW-1:0] q_i,
  input  wire logic [DW-1:0] d_i,
  output logic      [RW-1:0] rem_o,
  output logic      [QW-1:0] q_o
);

  logic [RW-1:0] dsh;
  logic          ge;
  logic [RW-1:0] rem_nxt;
  logic [QW-1:0] q_nxt;
  logic [RW-1:0] rem_r;
  logic [QW-1:0] q_r;

  always_comb begin
    dsh     = {{(RW-DW){1'b0}}, d_i} << SHIFT;
    ge      = (rem_i >= dsh);
    rem_nxt = ge ? (rem_i - dsh) : rem_i;
    q_nxt   = q_i | (QW'(ge) << SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign rem_o = rem_r;
  assign q_o   = q_r;

endmodule
`default_nettype wire

// ===== hw/rtl/grid_point_triangle_barycentric.sv =====
// Point location in a regular triangulated grid with barycentric weights.
// Input channel: in_valid, in_stall and the point coordinates point_x and
// point_z, a request being taken when in_valid is high and in_stall low.
// Result channel: out_valid, out_stall, hit, tri_index, weight_u, weight_v,
// one result for each input request, in order.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high and a write to an unknown index is ignored.
// Throughput is one request per cycle while the pipeline does not halt. The path
// from the accepting edge to out_valid runs through the chain of division cells: one
// cell per quotient bit, the column and row chains running side by side,
// then 17 cells for the weights, with six further register stages around them.
// The whole pipeline advances together; it halts only when a result sits in
// the output register while the receiver stalls, and in_stall then rises.
// Reset empties the pipeline and loads origin zero and unit spacing.
`default_nettype none
module grid_point_triangle_barycentric #(
  parameter int GRID_SIZE = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_point_x,
  input  wire logic [31:0] in_point_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_hit,
  output logic [12:0]      out_tri_index,
  output logic [20:0]      out_weight_u,
  output logic [20:0]      out_weight_v,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // Column and row quotient bits; 2^QB exceeds GRID_SIZE-1.
  localparam int QB   = $clog2(GRID_SIZE);
  localparam int RWC  = 33 + QB;
  localparam int LIMW = 31 + QB;
  localparam int FCW  = 2 * QB + 3;

  // Configuration registers and values derived from them.
  logic signed [31:0] ox_r, oz_r;
  logic [30:0]        sx_r, sz_r;
  logic [LIMW-1:0]    limx_r, limz_r;
  logic [61:0]        sqx_r, sqz_r;
  logic [62:0]        half_r;

  logic en;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r <= '0;
      oz_r <= '0;
      sx_r <= gptb_pkg::SPACING_RESET;
      sz_r <= gptb_pkg::SPACING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gptb_pkg::CFG_ORIGIN_X:  ox_r <= cfg_data;
        gptb_pkg::CFG_ORIGIN_Z:  oz_r <= cfg_data;
        gptb_pkg::CFG_SPACING_X: sx_r <= cfg_data[30:0];
        gptb_pkg::CFG_SPACING_Z: sz_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // The derived values are registered from the spacing registers and settle before any
  // request accepted after a write reaches the stages that read them.
  always_ff @(posedge clk) begin
    limx_r <= LIMW'({{QB{1'b0}}, sx_r} * LIMW'(GRID_SIZE - 1));
    limz_r <= LIMW'({{QB{1'b0}}, sz_r} * LIMW'(GRID_SIZE - 1));
    sqx_r  <= {31'd0, sx_r} * {31'd0, sx_r};
    sqz_r  <= {31'd0, sz_r} * {31'd0, sz_r};
    half_r <= 63'(({1'b0, sqx_r} + {1'b0, sqz_r}) >> 1);
  end

  // Stage 0: offsets from the origin.
  logic              v0_r;
  logic signed [32:0] offx_r, offz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      offx_r <= {in_point_x[31], in_point_x} - {ox_r[31], ox_r};
      offz_r <= {in_point_z[31], in_point_z} - {oz_r[31], oz_r};
    end
  end

  // Stage 1: magnitudes and range check. A negative offset is a hit only
  // when it is smaller than one step, and then lands in index zero.
  logic [32:0]    magx, magz;
  logic           missx, missz;
  logic           v1_r, miss1_r, negx1_r, negz1_r;
  logic [RWC-1:0] remx0_r, remz0_r;

  always_comb begin
    magx  = offx_r[32] ? 33'(-offx_r) : 33'(offx_r);
    magz  = offz_r[32] ? 33'(-offz_r) : 33'(offz_r);
    missx = offx_r[32] ? (magx >= {2'b0, sx_r})
                       : (RWC'(magx) >= RWC'(limx_r));
    missz = offz_r[32] ? (magz >= {2'b0, sz_r})
                       : (RWC'(magz) >= RWC'(limz_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      miss1_r <= missx || missz;
      negx1_r <= offx_r[32];
      negz1_r <= offz_r[32];
      remx0_r <= RWC'(magx);
      remz0_r <= RWC'(magz);
    end
  end

  // Column and row division chain, most significant quotient bit first.
  logic [RWC-1:0] remx [0:QB];
  logic [RWC-1:0] remz [0:QB];
  logic [QB-1:0]  qx   [0:QB];
  logic [QB-1:0]  qz   [0:QB];
  logic [QB-1:0]  cvld_r;
  logic [2:0]     cside_r [0:QB-1];

  assign remx[0] = remx0_r;
  assign remz[0] = remz0_r;
  assign qx[0]   = '0;
  assign qz[0]   = '0;

  for (genvar k = 0; k < QB; k++) begin : g_idx
    gptb_div_cell #(.RW(RWC), .DW(31), .QW(QB), .SHIFT(QB - 1 - k)) u_cx (
      .clk(clk), .en(en), .rem_i(remx[k]), .q_i(qx[k]), .d_i(sx_r),
      .rem_o(remx[k+1]), .q_o(qx[k+1])
    );
    gptb_div_cell #(.RW(RWC), .DW(31), .QW(QB), .SHIFT(QB - 1 - k)) u_cz (
      .clk(clk), .en(en), .rem_i(remz[k]), .q_i(qz[k]), .d_i(sz_r),
      .rem_o(remz[k+1]), .q_o(qz[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvld_r <= '0;
    end else if (en) begin
      cvld_r <= {cvld_r[QB-2:0], v1_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cside_r[0] <= {miss1_r, negx1_r, negz1_r};
      for (int i = 1; i < QB; i++) begin
        cside_r[i] <= cside_r[i-1];
      end
    end
  end

  // Fraction stage: signed offsets within the cell and the face base.
  logic               vf_r, missf_r;
  logic signed [31:0] fx_r, fz_r;
  logic [12:0]        facef_r;
  logic [FCW-1:0]     face_base;

  always_comb begin
    face_base = FCW'({1'b0, qx[QB]}) * FCW'(2)
              + FCW'(qz[QB]) * FCW'(2 * (GRID_SIZE - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= cvld_r[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      missf_r <= cside_r[QB-1][2];
      fx_r    <= cside_r[QB-1][1] ? -{1'b0, remx[QB][30:0]} : {1'b0, remx[QB][30:0]};
      fz_r    <= cside_r[QB-1][0] ? -{1'b0, remz[QB][30:0]} : {1'b0, remz[QB][30:0]};
      facef_r <= 13'(face_base);
    end
  end

  // Product stage for the nearer-corner test. Both operands are signed, so
  // they are sign-extended to the full product width.
  logic               vm_r, missm_r;
  logic signed [63:0] px_r, pz_r;
  logic signed [31:0] fxm_r, fzm_r;
  logic [12:0]        facem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (en) begin
      vm_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      missm_r <= missf_r;
      px_r    <= fx_r * $signed({1'b0, sx_r});
      pz_r    <= fz_r * $signed({1'b0, sz_r});
      fxm_r   <= fx_r;
      fzm_r   <= fz_r;
      facem_r <= facef_r;
    end
  end

  // Triangle choice and weight numerators. The lower-right triangle is
  // taken only when the point is strictly nearer its corner.
  logic signed [63:0] dot;
  logic               lr;
  logic signed [32:0] nx, nz;
  logic [32:0]        mnx, mnz;
  logic               vd_r;
  gptb_pkg::wside_t   sided_r;
  logic [gptb_pkg::RWV-1:0] remv0_r, remw0_r;

  always_comb begin
    dot = px_r + pz_r;
    lr  = (dot > $signed({1'b0, half_r}));
    nx  = lr ? ($signed({2'b0, sx_r}) - {fxm_r[31], fxm_r}) : {fxm_r[31], fxm_r};
    nz  = lr ? ($signed({2'b0, sz_r}) - {fzm_r[31], fzm_r}) : {fzm_r[31], fzm_r};
    mnx = nx[32] ? 33'(-nx) : 33'(nx);
    mnz = nz[32] ? 33'(-nz) : 33'(nz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sided_r.miss  <= missm_r;
      sided_r.face  <= facem_r + {12'd0, lr};
      sided_r.neg_v <= nx[32];
      sided_r.neg_w <= nz[32];
      remv0_r       <= gptb_pkg::RWV'({mnx, 16'd0});
      remw0_r       <= gptb_pkg::RWV'({mnz, 16'd0});
    end
  end

  // Weight division chain: numerator times one over the spacing.
  logic [gptb_pkg::RWV-1:0] remv [0:gptb_pkg::QV];
  logic [gptb_pkg::RWV-1:0] remw [0:gptb_pkg::QV];
  logic [gptb_pkg::QV-1:0]  qv   [0:gptb_pkg::QV];
  logic [gptb_pkg::QV-1:0]  qw   [0:gptb_pkg::QV];
  logic [gptb_pkg::QV-1:0]  wvld_r;
  gptb_pkg::wside_t         wside_r [0:gptb_pkg::QV-1];

  assign remv[0] = remv0_r;
  assign remw[0] = remw0_r;
  assign qv[0]   = '0;
  assign qw[0]   = '0;

  for (genvar k = 0; k < gptb_pkg::QV; k++) begin : g_wgt
    gptb_div_cell #(.RW(gptb_pkg::RWV), .DW(31), .QW(gptb_pkg::QV),
                    .SHIFT(gptb_pkg::QV - 1 - k)) u_cv (
      .clk(clk), .en(en), .rem_i(remv[k]), .q_i(qv[k]), .d_i(sx_r),
      .rem_o(remv[k+1]), .q_o(qv[k+1])
    );
    gptb_div_cell #(.RW(gptb_pkg::RWV), .DW(31), .QW(gptb_pkg::QV),
                    .SHIFT(gptb_pkg::QV - 1 - k)) u_cw (
      .clk(clk), .en(en), .rem_i(remw[k]), .q_i(qw[k]), .d_i(sz_r),
      .rem_o(remw[k+1]), .q_o(qw[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvld_r <= '0;
    end else if (en) begin
      wvld_r <= {wvld_r[gptb_pkg::QV-2:0], vd_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wside_r[0] <= sided_r;
      for (int i = 1; i < gptb_pkg::QV; i++) begin
        wside_r[i] <= wside_r[i-1];
      end
    end
  end

  // Output register: signs restored, u from v and w, misses forced to zero.
  gptb_pkg::wside_t sl;
  logic [20:0]      wv, ww, wu;
  logic             out_valid_r, hit_r;
  logic [12:0]      face_r;
  logic [20:0]      u_r, v_r;

  always_comb begin
    sl = wside_r[gptb_pkg::QV-1];
    wv = sl.neg_v ? -{4'd0, qv[gptb_pkg::QV]} : {4'd0, qv[gptb_pkg::QV]};
    ww = sl.neg_w ? -{4'd0, qw[gptb_pkg::QV]} : {4'd0, qw[gptb_pkg::QV]};
    wu = gptb_pkg::ONE_Q16 - wv - ww;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= wvld_r[gptb_pkg::QV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= !sl.miss;
      face_r <= sl.miss ? 13'd0 : sl.face;
      u_r    <= sl.miss ? 21'd0 : wu;
      v_r    <= sl.miss ? 21'd0 : wv;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = hit_r;
  assign out_tri_index = face_r;
  assign out_weight_u  = u_r;
  assign out_weight_v  = v_r;

endmodule
`default_nettype wire

// ===== dv/tb_grid_point_triangle_barycentric.sv =====
module tb_grid_point_triangle_barycentric;
  timeunit 1ns;
  timeprecision 1ps;

  // The grid is built with its default size; the prediction uses the same value.
  localparam int GRID_N = 64;
  // Acceptance to out_valid, through the block's register stages, plus a margin.
  localparam int SETTLE_CYCLES = $clog2(GRID_N) + 22 + 16;

  // One expected location result.
  typedef struct packed {
    logic                    hit;
    logic [gptb_pkg::FW-1:0] face;
    logic [gptb_pkg::WW-1:0] u;
    logic [gptb_pkg::WW-1:0] v;
  } location_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_point_x;
  logic [31:0] in_point_z;
  logic        out_valid;
  logic        out_stall;
  logic        out_hit;
  logic [12:0] out_tri_index;
  logic [20:0] out_weight_u;
  logic [20:0] out_weight_v;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  grid_point_triangle_barycentric #(.GRID_SIZE(GRID_N)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_point_x     (in_point_x),
    .in_point_z     (in_point_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_tri_index  (out_tri_index),
    .out_weight_u   (out_weight_u),
    .out_weight_v   (out_weight_v),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // The testbench's own copy of the grid registers, kept in step with every
  // write that the block accepts.
  longint grid_ox;
  longint grid_oz;
  longint grid_sx;
  longint grid_sz;

  location_t pending_locations[$];
  int        mismatch_count;
  int        burst_left;
  int        stall_mode;
  int        stall_left;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Works out where a point falls in the grid and its barycentric weights.
  // Divisions on longint truncate toward zero, which is what the column,
  // row and weight quotients need, including for small negative offsets.
  function automatic location_t locate_point(input logic [31:0] px, input logic [31:0] pz);
    longint    offx, offz, col, row, fx, fz, dot, wv, ww, wu, face;
    logic [63:0] half;
    location_t r;
    r = '0;
    if (grid_sx == 0 || grid_sz == 0) begin
      return r;
    end
    offx = longint'($signed(px)) - grid_ox;
    offz = longint'($signed(pz)) - grid_oz;
    col = offx / grid_sx;
    row = offz / grid_sz;
    if (col < 0 || row < 0 || col >= GRID_N - 1 || row >= GRID_N - 1) begin
      return r;
    end
    fx = offx - col * grid_sx;
    fz = offz - row * grid_sz;
    // The upper-left corner wins when it is nearer or the distances tie.
    dot = fx * grid_sx + fz * grid_sz;
    half = (64'(grid_sx * grid_sx) + 64'(grid_sz * grid_sz)) >> 1;
    face = 2 * col + 2 * row * (GRID_N - 1);
    if (dot <= longint'(half)) begin
      wv = (fx * 65536) / grid_sx;
      ww = (fz * 65536) / grid_sz;
    end else begin
      face = face + 1;
      wv = ((grid_sx - fx) * 65536) / grid_sx;
      ww = ((grid_sz - fz) * 65536) / grid_sz;
    end
    wu = 65536 - wv - ww;
    r.hit  = 1'b1;
    r.face = face[gptb_pkg::FW-1:0];
    r.u    = wu[gptb_pkg::WW-1:0];
    r.v    = wv[gptb_pkg::WW-1:0];
    return r;
  endfunction

  // Sends one point request and records its expected location. The sender
  // runs in bursts of random length and lowers valid only for a gap, so a
  // valid that stays high is never lowered and raised in the same step.
  task automatic send_point(input logic [31:0] px, input logic [31:0] pz);
    int gap;
    in_valid   <= 1'b1;
    in_point_x <= px;
    in_point_z <= pz;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    pending_locations.push_back(locate_point(px, pz));
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Holds the sender back until every expected result has come, then lets
  // the pipeline settle so that the block is idle for a register write.
  task automatic drain_grid;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_locations.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register and mirrors it in the prediction's copy. Indexes
  // past the last register are ignored by the block and by the copy alike.
  task automatic write_grid_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    case (idx)
      gptb_pkg::CFG_ORIGIN_X:  grid_ox = longint'($signed(data));
      gptb_pkg::CFG_ORIGIN_Z:  grid_oz = longint'($signed(data));
      gptb_pkg::CFG_SPACING_X: grid_sx = longint'(data[gptb_pkg::SPW-1:0]);
      gptb_pkg::CFG_SPACING_Z: grid_sz = longint'(data[gptb_pkg::SPW-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_grid(input logic [31:0] ox, input logic [31:0] oz,
                          input logic [31:0] sx, input logic [31:0] sz);
    write_grid_reg(gptb_pkg::CFG_ORIGIN_X, ox);
    write_grid_reg(gptb_pkg::CFG_ORIGIN_Z, oz);
    write_grid_reg(gptb_pkg::CFG_SPACING_X, sx);
    write_grid_reg(gptb_pkg::CFG_SPACING_Z, sz);
  endtask

  // Builds a point in a chosen cell of the current grid: the offset within
  // the cell may fall short of it or run past it, so edges and small
  // negative offsets come up as well as clean interior points.
  function automatic logic [31:0] grid_coord(input longint origin, input longint step);
    longint idx, frac, pos;
    case ($urandom_range(0, 9))
      0:       idx = -1;
      1:       idx = GRID_N - 1;
      2:       idx = GRID_N - 2;
      3:       idx = 0;
      default: idx = $urandom_range(0, GRID_N - 2);
    endcase
    case ($urandom_range(0, 7))
      0:       frac = 0;
      1:       frac = step - 1;
      2:       frac = -longint'($urandom_range(1, 3));
      3:       frac = step / 2;
      default: frac = (step > 1) ? longint'($urandom_range(0, 32'(step - 1))) : 0;
    endcase
    pos = origin + idx * step + frac;
    return pos[31:0];
  endfunction

  function automatic logic [31:0] pick_spacing;
    case ($urandom_range(0, 7))
      0:       return 32'd1;
      1:       return $urandom_range(1, 16);
      2:       return 32'h7fff_ffff;
      3:       return $urandom_range(32'h0100_0000, 32'h7fff_ffff);
      4:       return 32'd65536;
      default: return $urandom_range(256, 32'h0004_0000);
    endcase
  endfunction

  // Corners, edges, the tie between the two triangles and the field extremes
  // on the reset grid of unit spacing.
  task automatic test_reset_grid;
    send_point(32'd0, 32'd0);
    send_point(32'h0000_8000, 32'h0000_8000);   // exact tie picks upper-left
    send_point(32'h0000_8001, 32'h0000_8000);   // just past the tie
    send_point(32'h0000_ffff, 32'h0000_ffff);
    send_point(32'h0000_4000, 32'h0000_c000);
    send_point(32'h003e_ffff, 32'h003e_ffff);   // last cell, far corner
    send_point(32'h003f_0000, 32'h0001_0000);   // column past the grid
    send_point(32'h0001_0000, 32'h003f_0000);   // row past the grid
    send_point(32'hffff_ffff, 32'h0000_1000);   // small negative offset
    send_point(32'h0000_1000, 32'hffff_0001);
    send_point(32'hffff_0000, 32'h0000_0000);   // one full step below
    send_point(32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000);
    send_point(32'h0012_3456, 32'h0023_4567);
    drain_grid();
  endtask

  // Register extremes: the widest and narrowest spacing, origins at both
  // ends of their range, zero spacing and writes to unknown indexes.
  task automatic test_register_extremes;
    set_grid(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'hc000_0000, 32'h0000_0000);
    send_point(32'h0000_0000, 32'hffff_ffff);
    drain_grid();
    set_grid(32'h7fff_ffff, 32'h0000_0000, 32'd1, 32'd1);
    send_point(32'h7fff_ffff, 32'h0000_0000);
    send_point(32'h8000_0000, 32'h0000_0020);
    send_point(32'h7fff_fffe, 32'h0000_0001);
    drain_grid();
    set_grid(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    send_point(32'h0001_8000, 32'h0001_8000);   // zero spacing gives a miss
    drain_grid();
    // Bit 31 of a spacing write is dropped.
    set_grid(32'h0000_0000, 32'h0000_0000, 32'h8001_0000, 32'hffff_ffff);
    write_grid_reg(3'd4, 32'hdead_beef);
    write_grid_reg(3'd5, 32'h1234_5678);
    write_grid_reg(3'd6, 32'hffff_ffff);
    write_grid_reg(3'd7, 32'h0000_0000);
    send_point(32'h0002_8000, 32'h0000_0000);
    send_point(32'h0001_0000, 32'h7fff_0000);
    drain_grid();
  endtask

  // Random grids, each followed by a stream of points aimed mostly at cells
  // of that grid, with the rest anywhere in the coordinate range.
  task automatic test_random_points;
    int n;
    logic [31:0] px, pz;
    for (int phase = 0; phase < 12; phase++) begin
      set_grid($urandom, $urandom, pick_spacing(), pick_spacing());
      n = $urandom_range(90, 180);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) < 8) begin
          px = grid_coord(grid_ox, grid_sx);
          pz = grid_coord(grid_oz, grid_sz);
        end else begin
          px = $urandom;
          pz = $urandom;
        end
        send_point(px, pz);
      end
      drain_grid();
    end
    // Back to the reset values so that the last phase runs on a known grid.
    set_grid(32'd0, 32'd0, 32'd65536, 32'd65536);
    for (int i = 0; i < 120; i++) begin
      send_point(grid_coord(0, 65536), grid_coord(0, 65536));
    end
    drain_grid();
  endtask

  // The receiver changes its manner now and then: no stalls at all, light
  // random stalls, or heavy ones.
  always @(posedge clk) begin
    if (stall_left <= 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(10, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Compares each accepted result with the oldest expected location.
  always @(posedge clk) begin
    location_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_locations.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10) begin
          $display("Result with no request waiting: hit %0b face %0d u %h v %h",
                   out_hit, out_tri_index, out_weight_u, out_weight_v);
        end
      end else begin
        want = pending_locations.pop_front();
        if (out_hit !== want.hit || out_tri_index !== want.face ||
            out_weight_u !== want.u || out_weight_v !== want.v) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) begin
            $display("Mismatch: expected hit %0b face %0d u %h v %h, got hit %0b face %0d u %h v %h",
                     want.hit, want.face, want.u, want.v,
                     out_hit, out_tri_index, out_weight_u, out_weight_v);
          end
        end
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_point_x = '0;
    in_point_z = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    out_stall  = 1'b0;
    stall_mode = 0;
    stall_left = 0;
    burst_left = 0;
    mismatch_count = 0;
    grid_ox = 0;
    grid_oz = 0;
    grid_sx = 65536;
    grid_sz = 65536;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_grid();
    test_register_extremes();
    test_random_points();
    if (mismatch_count == 0 && pending_locations.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
